// ===== src/jsu_pkg.sv =====
// Shared types, status codes and helpers for the JSON string unescaper.
// No dependencies; imported by json_string_unescape_utf8.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  // Result status codes.
  localparam logic [2:0] ST_DATA   = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_NOQ    = 3'd2;
  localparam logic [2:0] ST_TRUNC  = 3'd3;
  localparam logic [2:0] ST_UNSUP  = 3'd4;
  localparam logic [2:0] ST_BADU   = 3'd5;
  localparam logic [2:0] ST_UNTERM = 3'd6;

  // Most results one text byte can cause.
  localparam int MaxResults = 4;

  // Character codes used by the parser.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  // One result item.
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] status;
  } result_t;

  // Hex digit decode: valid flag in bit 4, value in bits 3:0.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/json_string_unescape_utf8.sv =====
// JSON string unescaper with UTF-8 encoding of \u escapes.
// Depends on jsu_pkg for phase type, status codes and hex decode.
// Results of a text byte are registered; the first is presented in the cycle after acceptance.
// Throughput: one text byte per cycle while each byte gives at most one result and
// the output is not stalled; a byte that gives several results holds the input
// until the single output port has drained the buffer down to its last result.
// Reset: synchronous active-high rst returns the parser to idle and empties the buffer.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
  input  wire logic        s_tlast,   // end_of_text
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_byte
  output logic [2:0]       m_tuser,   // [2:0] status
  output logic             m_tlast    // last_of_run
);
  import jsu_pkg::*;

  // Parser state.
  phase_t      phase, phase_next;
  logic [1:0]  hex_seen, hex_seen_next;
  logic [15:0] code_point, code_point_next;

  // Result buffer: entry 0 is presented on the output.
  result_t     rbuf [MaxResults];
  logic [2:0]  cnt;

  // Results of the incoming byte.
  result_t     res [MaxResults];
  logic [2:0]  res_n;

  logic        in_xfer, out_xfer;
  logic [7:0]  b;
  logic        last;
  logic [4:0]  hex;
  logic [15:0] cp_new;
  logic        data_emitted;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  // Accept when the buffer is empty or its only result leaves this cycle.
  assign s_tready = (cnt == 3'd0) || (cnt == 3'd1 && m_tready);

  assign b      = s_tdata;
  assign last   = s_tlast;
  assign hex    = hex_decode(s_tdata);
  assign cp_new = {code_point[11:0], hex[3:0]};

  // Decode one text byte into next state and up to four results.
  always_comb begin
    phase_next      = phase;
    hex_seen_next   = hex_seen;
    code_point_next = code_point;
    res_n           = 3'd0;
    data_emitted    = 1'b0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = '{data: 8'h00, status: ST_DATA};
    end
    case (phase)
      PH_IDLE: begin
        if (b != CH_QUOTE) begin
          res[0] = '{data: 8'h00, status: ST_NOQ};
          res_n  = 3'd1;
        end else if (last) begin
          res[0] = '{data: 8'h00, status: ST_UNTERM};
          res_n  = 3'd1;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        if (b == CH_QUOTE) begin
          res[0]     = '{data: 8'h00, status: ST_DONE};
          res_n      = 3'd1;
          phase_next = PH_IDLE;
        end else if (b == CH_BSLASH) begin
          if (last) begin
            res[0]     = '{data: 8'h00, status: ST_TRUNC};
            res_n      = 3'd1;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_ESC;
          end
        end else begin
          res[0]       = '{data: b, status: ST_DATA};
          res_n        = 3'd1;
          data_emitted = 1'b1;
        end
      end
      PH_ESC: begin
        res_n        = 3'd1;
        data_emitted = 1'b1;
        phase_next   = PH_BODY;
        case (b)
          CH_QUOTE, CH_BSLASH, CH_SLASH: res[0] = '{data: b, status: ST_DATA};
          8'h62: res[0] = '{data: 8'h08, status: ST_DATA};
          8'h66: res[0] = '{data: 8'h0C, status: ST_DATA};
          8'h6E: res[0] = '{data: 8'h0A, status: ST_DATA};
          8'h72: res[0] = '{data: 8'h0D, status: ST_DATA};
          8'h74: res[0] = '{data: 8'h09, status: ST_DATA};
          CH_LOW_U: begin
            data_emitted = 1'b0;
            if (last) begin
              res[0]     = '{data: 8'h00, status: ST_BADU};
              phase_next = PH_IDLE;
            end else begin
              res_n           = 3'd0;
              phase_next      = PH_HEX;
              hex_seen_next   = 2'd0;
              code_point_next = 16'h0000;
            end
          end
          default: begin
            data_emitted = 1'b0;
            res[0]       = '{data: 8'h00, status: ST_UNSUP};
            phase_next   = PH_IDLE;
          end
        endcase
      end
      PH_HEX: begin
        if (!hex[4]) begin
          res[0]     = '{data: 8'h00, status: ST_BADU};
          res_n      = 3'd1;
          phase_next = PH_IDLE;
        end else if (hex_seen != 2'd3) begin
          if (last) begin
            res[0]     = '{data: 8'h00, status: ST_BADU};
            res_n      = 3'd1;
            phase_next = PH_IDLE;
          end else begin
            code_point_next = cp_new;
            hex_seen_next   = hex_seen + 2'd1;
          end
        end else begin
          // Fourth digit: encode the code point as UTF-8.
          if (cp_new <= 16'h007F) begin
            res[0] = '{data: cp_new[7:0], status: ST_DATA};
            res_n  = 3'd1;
          end else if (cp_new <= 16'h07FF) begin
            res[0] = '{data: {3'b110, cp_new[10:6]}, status: ST_DATA};
            res[1] = '{data: {2'b10, cp_new[5:0]}, status: ST_DATA};
            res_n  = 3'd2;
          end else begin
            res[0] = '{data: {4'b1110, cp_new[15:12]}, status: ST_DATA};
            res[1] = '{data: {2'b10, cp_new[11:6]}, status: ST_DATA};
            res[2] = '{data: {2'b10, cp_new[5:0]}, status: ST_DATA};
            res_n  = 3'd3;
          end
          data_emitted    = 1'b1;
          phase_next      = PH_BODY;
          hex_seen_next   = 2'd0;
          code_point_next = 16'h0000;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    // Text ending after data closes with an unterminated result and goes idle.
    if (data_emitted && last) begin
      res[res_n[1:0]] = '{data: 8'h00, status: ST_UNTERM};
      res_n           = res_n + 3'd1;
      phase_next      = PH_IDLE;
    end
    if (phase_next == PH_IDLE) begin
      hex_seen_next   = 2'd0;
      code_point_next = 16'h0000;
    end
  end

  // Parser state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hex_seen   <= 2'd0;
      code_point <= 16'h0000;
    end else if (in_xfer) begin
      phase      <= phase_next;
      hex_seen   <= hex_seen_next;
      code_point <= code_point_next;
    end
  end

  // Result count: load on a new byte, count down as results leave.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (in_xfer) begin
      cnt <= res_n;
    end else if (out_xfer) begin
      cnt <= cnt - 3'd1;
    end
  end

  // Result payload: load a new burst or shift toward the output.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < MaxResults; i++) begin
        rbuf[i] <= res[i];
      end
    end else if (out_xfer) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        rbuf[i] <= rbuf[i + 1];
      end
    end
  end

  // Output side.
  assign m_tvalid = (cnt != 3'd0);
  assign m_tdata  = rbuf[0].data;
  assign m_tuser  = rbuf[0].status;
  assign m_tlast  = (cnt == 3'd1);

endmodule

`default_nettype wire
